@@ src/rgb_to_hsv_converter_macros.svh @@
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Both macros sample on the rising edge of clk_i and are off while rst_ni is low.

// The consequent must hold in the same cycle as the antecedent.
`define RGBHSV_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_converter: implication check failed");

// The condition must hold at every clock edge outside reset.
`define RGBHSV_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("rgb_to_hsv_converter: invariant check failed");

`endif

@@ src/rgbhsv_pkg.sv @@
`timescale 1ns / 1ps

package rgbhsv_pkg;

  // Quotient bits produced by the divider, one per pipeline stage.
  localparam int QUO_BITS       = 17;
  localparam int HUE_BITS       = 16;
  localparam int SAT_BITS       = 17;
  localparam int BRIGHT_BITS    = 8;
  localparam int IN_CHAN_BITS   = 8;
  // Fraction bits of degrees (Q9.6) and of a turn fraction (Q0.16).
  localparam int HUE_DEG_SHIFT  = 6;
  localparam int HUE_NORM_SHIFT = 16;
  localparam int SAT_SHIFT      = 16;
  localparam int OUT_DATA_BITS  = 48;
  localparam int OUT_PAD_BITS   = OUT_DATA_BITS - HUE_BITS - SAT_BITS - BRIGHT_BITS;

  typedef enum logic [1:0] {
    SEC_RED_UP,
    SEC_RED_WRAP,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // Data that rides along the divider stages next to the quotients.
  typedef struct packed {
    logic [BRIGHT_BITS-1:0] bright;
    logic                   hue_zero;
    logic                   sat_zero;
  } side_t;

endpackage

@@ src/rgb_to_hsv_converter.sv @@
`timescale 1ns / 1ps
// Channel     Direction  Handshake               Payload
// s_axis      in         tvalid / tready         tdata: red, green, blue
// m_axis      out        tvalid / tready         tdata: hue, saturation, brightness
// cfg         in         cfg_we_i (no wait)      cfg_wdata_i: hue_normalized
//
// While m_axis does not stall, one pixel is accepted per clock and results
// leave one per clock. Two front stages (min/max and hue numerator) are followed
// by a 17-stage restoring divider that settles one quotient bit per stage.
// Reset is asynchronous and active low; it clears all valid bits and the mode bit.
// A stall on m_axis only backs up as far as the first empty stage, so the input
// keeps taking items until every stage, the output register included, is full.

`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // hue_normalized
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // [7:0] red, [15:8] green, [23:16] blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata     // [15:0] hue, [32:16] saturation,
                                       // [40:33] brightness, [47:41] zero
);
  import rgbhsv_pkg::*;

  localparam int CW = CHANNEL_BITS;
  // Hue numerator n = 360*d at most, so it needs nine bits above the channel.
  localparam int NH = CW + 9;
  localparam int NW = NH + HUE_NORM_SHIFT;
  localparam int SN = CW + SAT_SHIFT;

  // Mode register: degrees in Q9.6 or a fraction of a turn in Q0.16.
  logic hue_norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_norm_q <= 1'b0;
    end else if (cfg_we_i) begin
      hue_norm_q <= cfg_wdata_i;
    end
  end

  // Stage A: largest and smallest channel, sector, and the signed hue difference.
  logic [CW-1:0]   r_c, g_c, b_c;
  logic [CW-1:0]   mx_c, mn_c;
  sector_e         sec_c;
  logic signed [CW:0] num_c;

  logic            va_q;
  logic [CW-1:0]   mxa_q, da_q;
  sector_e         seca_q;
  logic signed [CW:0] numa_q;

  logic            en_a, en_b, div_ready;

  assign r_c = CW'(s_axis_tdata[IN_CHAN_BITS-1:0]);
  assign g_c = CW'(s_axis_tdata[2*IN_CHAN_BITS-1:IN_CHAN_BITS]);
  assign b_c = CW'(s_axis_tdata[3*IN_CHAN_BITS-1:2*IN_CHAN_BITS]);

  always_comb begin
    mx_c = r_c;
    if (g_c > mx_c) mx_c = g_c;
    if (b_c > mx_c) mx_c = b_c;
    mn_c = r_c;
    if (g_c < mn_c) mn_c = g_c;
    if (b_c < mn_c) mn_c = b_c;
  end

  // Ties go to red first, then green.
  always_comb begin
    priority if (r_c == mx_c) begin
      sec_c = (g_c >= b_c) ? SEC_RED_UP : SEC_RED_WRAP;
    end else if (g_c == mx_c) begin
      sec_c = SEC_GREEN;
    end else begin
      sec_c = SEC_BLUE;
    end
  end

  always_comb begin
    unique case (sec_c)
      SEC_RED_UP,
      SEC_RED_WRAP: num_c = {1'b0, g_c} - {1'b0, b_c};
      SEC_GREEN:    num_c = {1'b0, b_c} - {1'b0, r_c};
      SEC_BLUE:     num_c = {1'b0, r_c} - {1'b0, g_c};
      default:      num_c = '0;
    endcase
  end

  assign en_a          = !va_q || en_b;
  assign s_axis_tready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      mxa_q  <= mx_c;
      da_q   <= mx_c - mn_c;
      seca_q <= sec_c;
      numa_q <= num_c;
    end
  end

  // Stage B: hue numerator n = off*d + 60*num, then the dividend and divisor
  // of both divisions, with the dividend split into its top part and the
  // seventeen bits that the divider shifts in.
  logic [NH-1:0]        d_ext, d120, d240, d360, off_d;
  logic signed [NH:0]   num_ext, n60, n_full;
  logic [NH-1:0]        n_c;
  logic [NW-1:0]        n_shift;
  logic [SN-1:0]        s_shift;

  logic                 vb_q;
  logic [NH-1:0]        hue_rem_q, hue_den_q;
  logic [QUO_BITS-1:0]  hue_low_q, sat_low_q;
  logic [CW-1:0]        sat_rem_q, sat_den_q;
  side_t                side_q;

  assign d_ext = NH'(da_q);
  assign d360  = (d_ext << 8) + (d_ext << 6) + (d_ext << 5) + (d_ext << 3);
  assign d120  = (d_ext << 7) - (d_ext << 3);
  assign d240  = d120 << 1;

  always_comb begin
    unique case (seca_q)
      SEC_RED_UP:   off_d = '0;
      SEC_RED_WRAP: off_d = d360;
      SEC_GREEN:    off_d = d120;
      SEC_BLUE:     off_d = d240;
      default:      off_d = '0;
    endcase
  end

  // 60 * num as 64 * num - 4 * num; the sum is never negative.
  assign num_ext = {{(NH - CW){numa_q[CW]}}, numa_q};
  assign n60     = (num_ext <<< 6) - (num_ext <<< 2);
  assign n_full  = $signed({1'b0, off_d}) + n60;
  assign n_c     = n_full[NH-1:0];

  assign n_shift = hue_norm_q ? (NW'(n_c) << HUE_NORM_SHIFT) : (NW'(n_c) << HUE_DEG_SHIFT);
  assign s_shift = SN'(da_q) << SAT_SHIFT;

  assign en_b = !vb_q || div_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      hue_rem_q       <= NH'(n_shift >> QUO_BITS);
      hue_low_q       <= n_shift[QUO_BITS-1:0];
      hue_den_q       <= hue_norm_q ? d360 : d_ext;
      sat_rem_q       <= CW'(s_shift >> QUO_BITS);
      sat_low_q       <= s_shift[QUO_BITS-1:0];
      sat_den_q       <= mxa_q;
      side_q.bright   <= BRIGHT_BITS'(mxa_q);
      side_q.hue_zero <= (da_q == '0);
      side_q.sat_zero <= (mxa_q == '0);
    end
  end

  // Divider stages; the last one is the output register.
  logic [QUO_BITS-1:0] hue_quo, sat_quo;
  side_t               side_out;
  logic [HUE_BITS-1:0] hue_out;
  logic [SAT_BITS-1:0] sat_out;

  rgbhsv_div #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vb_q),
    .in_ready_o  (div_ready),
    .hue_rem_i   (hue_rem_q),
    .hue_low_i   (hue_low_q),
    .hue_den_i   (hue_den_q),
    .sat_rem_i   (sat_rem_q),
    .sat_low_i   (sat_low_q),
    .sat_den_i   (sat_den_q),
    .side_i      (side_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .hue_quo_o   (hue_quo),
    .sat_quo_o   (sat_quo),
    .side_o      (side_out)
  );

  // A grey pixel has no hue and a black pixel no saturation; the divider
  // output for a zero divisor is discarded here.
  assign hue_out = side_out.hue_zero ? '0 : hue_quo[HUE_BITS-1:0];
  assign sat_out = side_out.sat_zero ? '0 : SAT_BITS'(sat_quo);

  assign m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, side_out.bright, sat_out, hue_out};

  // Input stalls only when every stage is full and the output is held.
  `RGBHSV_ASSERT_ALWAYS(a_stall_only_when_full,
    s_axis_tready || (m_axis_tvalid && !m_axis_tready))

  // Saturation never exceeds one in Q1.16.
  `RGBHSV_ASSERT_IMPLIES(a_sat_range, m_axis_tvalid,
    m_axis_tdata[HUE_BITS+SAT_BITS-1:HUE_BITS] <= SAT_BITS'(1 << SAT_SHIFT))

  // Zero saturation means max equals min, so the hue must be zero too.
  `RGBHSV_ASSERT_IMPLIES(a_grey_hue,
    m_axis_tvalid && (m_axis_tdata[HUE_BITS+SAT_BITS-1:HUE_BITS] == '0),
    m_axis_tdata[HUE_BITS-1:0] == '0)

endmodule

@@ src/rgbhsv_div.sv @@
`timescale 1ns / 1ps

module rgbhsv_div #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic [CHANNEL_BITS+8:0]                      hue_rem_i,
  input  logic [rgbhsv_pkg::QUO_BITS-1:0]              hue_low_i,
  input  logic [CHANNEL_BITS+8:0]                      hue_den_i,
  input  logic [CHANNEL_BITS-1:0]                      sat_rem_i,
  input  logic [rgbhsv_pkg::QUO_BITS-1:0]              sat_low_i,
  input  logic [CHANNEL_BITS-1:0]                      sat_den_i,
  input  rgbhsv_pkg::side_t                            side_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic [rgbhsv_pkg::QUO_BITS-1:0]              hue_quo_o,
  output logic [rgbhsv_pkg::QUO_BITS-1:0]              sat_quo_o,
  output rgbhsv_pkg::side_t                            side_o
);
  import rgbhsv_pkg::*;

  localparam int DH = CHANNEL_BITS + 9;
  localparam int DS = CHANNEL_BITS;

  logic                v_q  [QUO_BITS];
  logic                en   [QUO_BITS];
  logic [DH-1:0]       hr_q [QUO_BITS];
  logic [QUO_BITS-1:0] hl_q [QUO_BITS];
  logic [DH-1:0]       hd_q [QUO_BITS];
  logic [QUO_BITS-1:0] hq_q [QUO_BITS];
  logic [DS-1:0]       sr_q [QUO_BITS];
  logic [QUO_BITS-1:0] sl_q [QUO_BITS];
  logic [DS-1:0]       sd_q [QUO_BITS];
  logic [QUO_BITS-1:0] sq_q [QUO_BITS];
  side_t               sb_q [QUO_BITS];

  logic                v_in  [QUO_BITS];
  logic [DH-1:0]       hr_in [QUO_BITS];
  logic [QUO_BITS-1:0] hl_in [QUO_BITS];
  logic [DH-1:0]       hd_in [QUO_BITS];
  logic [QUO_BITS-1:0] hq_in [QUO_BITS];
  logic [DS-1:0]       sr_in [QUO_BITS];
  logic [QUO_BITS-1:0] sl_in [QUO_BITS];
  logic [DS-1:0]       sd_in [QUO_BITS];
  logic [QUO_BITS-1:0] sq_in [QUO_BITS];
  side_t               sb_in [QUO_BITS];

  // Restoring division, one quotient bit per stage from the top down.
  // Each stage shifts in one numerator bit and subtracts the divisor if it fits.
  for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
    localparam int K = QUO_BITS - 1 - s;

    logic [DH:0]   h_t;
    logic          h_ge;
    logic [DH-1:0] hr_d;
    logic [DS:0]   s_t;
    logic          s_ge;
    logic [DS-1:0] sr_d;

    if (s == 0) begin : g_src
      assign v_in[s]  = in_valid_i;
      assign hr_in[s] = hue_rem_i;
      assign hl_in[s] = hue_low_i;
      assign hd_in[s] = hue_den_i;
      assign hq_in[s] = '0;
      assign sr_in[s] = sat_rem_i;
      assign sl_in[s] = sat_low_i;
      assign sd_in[s] = sat_den_i;
      assign sq_in[s] = '0;
      assign sb_in[s] = side_i;
    end else begin : g_chain
      assign v_in[s]  = v_q[s-1];
      assign hr_in[s] = hr_q[s-1];
      assign hl_in[s] = hl_q[s-1];
      assign hd_in[s] = hd_q[s-1];
      assign hq_in[s] = hq_q[s-1];
      assign sr_in[s] = sr_q[s-1];
      assign sl_in[s] = sl_q[s-1];
      assign sd_in[s] = sd_q[s-1];
      assign sq_in[s] = sq_q[s-1];
      assign sb_in[s] = sb_q[s-1];
    end

    // A stage loads when it is empty or its item moves on in the same cycle.
    if (s == QUO_BITS - 1) begin : g_last
      assign en[s] = !v_q[s] || out_ready_i;
    end else begin : g_mid
      assign en[s] = !v_q[s] || en[s+1];
    end

    assign h_t  = {hr_in[s], hl_in[s][K]};
    assign h_ge = h_t >= {1'b0, hd_in[s]};
    assign hr_d = h_ge ? DH'(h_t - {1'b0, hd_in[s]}) : h_t[DH-1:0];

    assign s_t  = {sr_in[s], sl_in[s][K]};
    assign s_ge = s_t >= {1'b0, sd_in[s]};
    assign sr_d = s_ge ? DS'(s_t - {1'b0, sd_in[s]}) : s_t[DS-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        hr_q[s] <= hr_d;
        hl_q[s] <= hl_in[s];
        hd_q[s] <= hd_in[s];
        hq_q[s] <= {hq_in[s][QUO_BITS-2:0], h_ge};
        sr_q[s] <= sr_d;
        sl_q[s] <= sl_in[s];
        sd_q[s] <= sd_in[s];
        sq_q[s] <= {sq_in[s][QUO_BITS-2:0], s_ge};
        sb_q[s] <= sb_in[s];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[QUO_BITS-1];
  assign hue_quo_o   = hq_q[QUO_BITS-1];
  assign sat_quo_o   = sq_q[QUO_BITS-1];
  assign side_o      = sb_q[QUO_BITS-1];

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import rgbhsv_pkg::*;

  typedef struct packed {
    logic [HUE_BITS-1:0]    hue;
    logic [SAT_BITS-1:0]    sat;
    logic [BRIGHT_BITS-1:0] bright;
  } hsv_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;    // [7:0] red, [15:8] green, [23:16] blue
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;          // [15:0] hue, [32:16] saturation,
                                      // [40:33] brightness, [47:41] zero

  // Our copy of the mode register, and the colors we expect back, oldest first.
  logic hue_norm_mode = 1'b0;
  hsv_t pending_hsv[$];
  int   mismatch_count = 0;
  int   tx_idle_pct    = 34;
  int   rx_idle_pct    = 34;
  int   rx_hold_cycles = 0;

  rgb_to_hsv_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hexcone conversion done on wide integers, truncating every quotient.
  function automatic hsv_t predict_hsv(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic norm);
    longint  mx, mn, d, num, off, n, hue, sat;
    sector_e sec;
    hsv_t    res;
    mx = longint'(r);
    if (longint'(g) > mx) mx = longint'(g);
    if (longint'(b) > mx) mx = longint'(b);
    mn = longint'(r);
    if (longint'(g) < mn) mn = longint'(g);
    if (longint'(b) < mn) mn = longint'(b);
    d   = mx - mn;
    hue = 0;
    sat = 0;
    if (d != 0) begin
      // Ties go to red first, then to green.
      if (longint'(r) == mx) sec = (g >= b) ? SEC_RED_UP : SEC_RED_WRAP;
      else if (longint'(g) == mx) sec = SEC_GREEN;
      else sec = SEC_BLUE;
      case (sec)
        SEC_RED_UP: begin
          num = longint'(g) - longint'(b);
          off = 0;
        end
        SEC_RED_WRAP: begin
          num = longint'(g) - longint'(b);
          off = 360;
        end
        SEC_GREEN: begin
          num = longint'(b) - longint'(r);
          off = 120;
        end
        default: begin
          num = longint'(r) - longint'(g);
          off = 240;
        end
      endcase
      n = off * d + 60 * num;
      if (n < 0) n = 0;
      if (norm) hue = (n * (longint'(1) << HUE_NORM_SHIFT)) / (d * 360);
      else hue = (n * (longint'(1) << HUE_DEG_SHIFT)) / d;
    end
    if (mx != 0) sat = (d * (longint'(1) << SAT_SHIFT)) / mx;
    res.hue    = HUE_BITS'(hue);
    res.sat    = SAT_BITS'(sat);
    res.bright = BRIGHT_BITS'(mx);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint expected, longint actual);
    $display("%0t ns: mismatch in %s: expected 0x%0h, got 0x%0h",
             $time, what, expected, actual);
    mismatch_count++;
  endtask

  // Every pixel the block takes is converted right away into its expected color.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      pending_hsv.push_back(predict_hsv(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                        s_axis_tdata[23:16], hue_norm_mode));
  end

  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_hsv.size() == 0) begin
        report_mismatch("result with no pixel pending", 0, longint'(m_axis_tdata));
      end else begin
        want = pending_hsv.pop_front();
        if (m_axis_tdata[15:0] !== want.hue)
          report_mismatch("hue", longint'(want.hue), longint'(m_axis_tdata[15:0]));
        if (m_axis_tdata[32:16] !== want.sat)
          report_mismatch("saturation", longint'(want.sat),
                          longint'(m_axis_tdata[32:16]));
        if (m_axis_tdata[40:33] !== want.bright)
          report_mismatch("brightness", longint'(want.bright),
                          longint'(m_axis_tdata[40:33]));
        if (m_axis_tdata[47:41] !== '0)
          report_mismatch("padding", 0, longint'(m_axis_tdata[47:41]));
      end
    end
  end

  // The receiver stalls at random, or for a whole hold-off when one is requested.
  always @(posedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles = rx_hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Each cycle before an item the sender idles with the given chance.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering pixels and waits until every expected color is back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_hue_mode(logic norm);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= norm;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    hue_norm_mode = norm;
    @(posedge clk_i);
  endtask

  // A pixel shaped to reach grey, tie and extreme cases often.
  task automatic send_random_pixel();
    logic [7:0] top, low, c0, c1, c2;
    top = 8'($urandom_range(1, 255));
    low = 8'($urandom_range(0, top - 1));
    case ($urandom_range(0, 9))
      0: begin
        c0 = 8'($urandom_range(0, 255));
        send_pixel(c0, c0, c0);
      end
      1: begin
        case ($urandom_range(0, 2))
          0: send_pixel(top, top, low);
          1: send_pixel(top, low, top);
          default: send_pixel(low, top, top);
        endcase
      end
      2: begin
        c0 = $urandom_range(0, 1) ? 8'hff : 8'h00;
        c1 = $urandom_range(0, 1) ? 8'hff : 8'h00;
        c2 = $urandom_range(0, 1) ? 8'hff : 8'h00;
        send_pixel(c0, c1, c2);
      end
      3: send_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                    8'($urandom_range(0, 3)));
      default: send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic test_corner_pixels(logic norm);
    write_hue_mode(norm);
    send_pixel(8'd0,   8'd0,   8'd0);     // black: no hue, no saturation
    send_pixel(8'd255, 8'd255, 8'd255);   // white
    send_pixel(8'd128, 8'd128, 8'd128);   // mid grey
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);     // red and green tie, red wins
    send_pixel(8'd0,   8'd255, 8'd255);   // green and blue tie, green wins
    send_pixel(8'd255, 8'd0,   8'd255);   // red and blue tie, hue wraps
    send_pixel(8'd255, 8'd10,  8'd5);     // red largest, green above blue
    send_pixel(8'd200, 8'd30,  8'd90);    // red largest, blue above green
    send_pixel(8'd1,   8'd0,   8'd0);     // smallest nonzero maximum
    send_pixel(8'd254, 8'd255, 8'd254);   // spread of one
    send_pixel(8'd85,  8'd170, 8'd255);   // blue largest, alternating bits
  endtask

  // Phases of random pixels, the mode written anew before each phase.
  task automatic test_random_phases(int phases);
    int count;
    for (int p = 0; p < phases; p++) begin
      write_hue_mode(p % 3 == 1 ? 1'b0 : logic'($urandom_range(0, 1)));
      count = $urandom_range(40, 100);
      repeat (count) send_random_pixel();
      // Now and then the sender simply waits for the pipeline to empty.
      if ($urandom_range(0, 1) == 1) drain_results();
    end
  endtask

  // The receiver holds off long enough for every stage to fill and stall the input.
  task automatic test_back_pressure();
    write_hue_mode(1'b1);
    tx_idle_pct    = 0;
    rx_hold_cycles = 80;
    repeat (60) send_random_pixel();
    tx_idle_pct = 34;
  endtask

  task automatic test_no_idle_stream();
    write_hue_mode(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (100) send_random_pixel();
    tx_idle_pct = 34;
    rx_idle_pct = 34;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_pixels(1'b0);
    test_corner_pixels(1'b1);
    test_random_phases(8);
    test_back_pressure();
    test_no_idle_stream();
    test_random_phases(2);
    drain_results();
    repeat (25) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS rgb_to_hsv_converter");
    end else begin
      $display("FAIL rgb_to_hsv_converter");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL rgb_to_hsv_converter");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/rgbhsv_pkg.sv
src/rgbhsv_div.sv
src/rgb_to_hsv_converter.sv
verif/tb.sv
